/* hdl/aenc_pkg.sv */
//------------------------------------------------------------------------------
// aenc_pkg
// Shared types and command codes for the static-model arithmetic encoder.
//------------------------------------------------------------------------------
package aenc_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    // Unassigned code; the block ignores it.
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    // One input word.
    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  table_index;
        logic [29:0] table_value;
        logic [5:0]  symbol;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic        lead_bit;
        logic [31:0] follow_count;
        logic        last_of_item;
        logic        end_of_stream;
    } t_out_word;

endpackage

/* hdl/arithmetic_encoder_static_model.sv */
//------------------------------------------------------------------------------
// arithmetic_encoder_static_model
// Integer arithmetic encoder with a static cumulative frequency table.
//------------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid/o_stall, i_data) takes one word at a time:
//   a load word writes one cumulative table entry, an encode word codes one
//   symbol, a flush word emits the final bit group and restarts the bounds.
//   Results leave on o_valid/i_stall, o_data, one bit group per word.
// Timing:
//   A load, an unknown command or an out-of-range symbol is handled in the
//   idle state. An encode reads three table entries (one memory read port;
//   a zero total ends it before the products), then runs two shift-and-add
//   multiplications and two restoring divisions, one bit per cycle, plus
//   an update state. Renormalization then runs at most CODE_BITS+2 steps
//   and a final stop that ends the item. Each word is shown one step after
//   it is formed, so the last one can carry its flag. A flush passes through
//   its own state. No new word is taken while a result waits.
// Reset:
//   Bounds and underflow count return to their start values. The table is
//   not cleared; entries must be loaded before use.
// Stall:
//   A result waits in the output register while i_stall is high; the
//   renormalization holds until it is taken.
//------------------------------------------------------------------------------
module arithmetic_encoder_static_model #(
    parameter int SYMBOL_COUNT = 64,
    parameter int CODE_BITS    = 32,
    parameter int COUNT_BITS   = 30
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  aenc_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output aenc_pkg::t_out_word  o_data
);

    localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int PW = CODE_BITS + 1 + COUNT_BITS;      // product width
    localparam int CW = $clog2(PW + 1);
    localparam logic [CODE_BITS-1:0] CODE_MAX      = {CODE_BITS{1'b1}};
    localparam logic [CODE_BITS-1:0] CODE_HALF     = CODE_MAX ^ (CODE_MAX >> 1);
    localparam logic [CODE_BITS-1:0] CODE_QUARTER  = CODE_HALF >> 1;
    localparam logic [CODE_BITS-1:0] CODE_3QUARTER = CODE_HALF | CODE_QUARTER;
    localparam logic [31:0] UF_MAX = 32'hFFFF_FFFF;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_RD3   = 4'd11;
    localparam logic [3:0] S_MULH  = 4'd4;
    localparam logic [3:0] S_DIVH  = 4'd5;
    localparam logic [3:0] S_MULL  = 4'd6;
    localparam logic [3:0] S_DIVL  = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_RENRM = 4'd9;
    localparam logic [3:0] S_FLUSH = 4'd10;

    logic [COUNT_BITS-1:0] r_mem [SYMBOL_COUNT];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [AW-1:0]         n_raddr;
    logic                  rd_en;

    logic [3:0]            r_state;
    logic [CODE_BITS-1:0]  r_low, r_high;
    logic [31:0]           r_uf;
    logic [AW-1:0]         r_sym;
    logic [COUNT_BITS-1:0] r_total, r_plow;
    logic [CODE_BITS:0]    r_range;
    // shift-and-add multiplier then restoring divider, one bit a cycle
    logic [PW-1:0]         r_acc;      // product, later quotient
    logic [COUNT_BITS:0]   r_rem;
    logic [COUNT_BITS-1:0] r_mplier;
    logic [CW-1:0]         r_cnt;
    logic [CODE_BITS-1:0]  r_qh;
    logic [5:0]            r_steps;
    logic                  r_any;
    aenc_pkg::t_out_word   r_pend;
    logic                  r_ovalid;
    aenc_pkg::t_out_word   r_odata;

    logic                  in_acc, out_free, out_load;
    logic [COUNT_BITS:0]   rem_sh, rem_sub;
    logic                  rn_emit, rn_lead, rn_mid, rn_stop;
    logic [CODE_BITS-1:0]  rn_low, rn_high;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;

    // Table memory: one write, one registered read.
    always_comb begin
        n_raddr = r_sym;
        rd_en   = 1'b0;
        unique case (r_state)
            S_RD0:   begin n_raddr = AW'(SYMBOL_COUNT - 1); rd_en = 1'b1; end
            S_RD1:   begin n_raddr = r_sym; rd_en = 1'b1; end
            S_RD2:   begin n_raddr = r_sym + 1'b1; rd_en = 1'b1; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_data.command == aenc_pkg::CMD_LOAD &&
            32'(i_data.table_index) < SYMBOL_COUNT) begin
            r_mem[AW'(i_data.table_index)] <= i_data.table_value[COUNT_BITS-1:0];
        end
        if (rd_en) begin
            r_rdata <= r_mem[n_raddr];
        end
    end

    // Divider step: shift in next dividend bit from top of r_acc.
    assign rem_sh  = {r_rem[COUNT_BITS-1:0], r_acc[PW-1]};
    assign rem_sub = rem_sh - {1'b0, r_total};

    // One renormalization step; emits when the top bits agree.
    always_comb begin
        rn_emit = (r_high < CODE_HALF) || (r_low >= CODE_HALF);
        rn_lead = !(r_high < CODE_HALF);
        rn_mid  = (r_low >= CODE_QUARTER) && (r_high < CODE_3QUARTER);
        rn_stop = (!rn_emit && !rn_mid) || (32'(r_steps) > CODE_BITS + 1);
        rn_low  = rn_emit ? r_low : r_low - CODE_QUARTER;
        rn_high = rn_emit ? r_high : r_high - CODE_QUARTER;
    end

    // The output register is loaded whenever a finished word moves into it.
    assign out_load = out_free &&
                      ((r_state == S_RENRM && r_any && (rn_stop || rn_emit)) ||
                       r_state == S_FLUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // Control and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_low    <= '0;
            r_high   <= CODE_MAX;
            r_uf     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (in_acc) begin
                    r_sym <= AW'(i_data.symbol);
                    if (i_data.command == aenc_pkg::CMD_ENCODE &&
                        32'(i_data.symbol) + 1 < SYMBOL_COUNT)
                        r_state <= S_RD0;
                    else if (i_data.command == aenc_pkg::CMD_FLUSH)
                        r_state <= S_FLUSH;
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin r_total <= r_rdata; r_state <= S_RD2; end
                S_RD2: begin
                    r_plow  <= r_rdata;
                    r_range <= {1'b0, r_high} - {1'b0, r_low} + 1'b1;
                    if (r_total == '0) r_state <= S_IDLE;
                    else r_state <= S_RD3;
                end
                // The upper cumulative count arrives; start the first product.
                S_RD3: begin
                    r_mplier <= r_rdata;
                    r_acc    <= '0;
                    r_cnt    <= CW'(COUNT_BITS);
                    r_state  <= S_MULH;
                end
                S_MULH: begin
                    if (r_cnt != '0) begin
                        r_acc    <= (r_acc << 1) +
                                    (r_mplier[COUNT_BITS-1] ? PW'(r_range) : '0);
                        r_mplier <= r_mplier << 1;
                        r_cnt    <= r_cnt - 1'b1;
                    end else begin
                        r_rem   <= '0;
                        r_cnt   <= CW'(PW);
                        r_state <= S_DIVH;
                    end
                end
                S_DIVH, S_DIVL: begin
                    if (r_cnt != '0) begin
                        if (!rem_sub[COUNT_BITS]) begin
                            r_rem <= rem_sub;
                            r_acc <= {r_acc[PW-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_acc <= {r_acc[PW-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end else if (r_state == S_DIVH) begin
                        r_qh     <= r_acc[CODE_BITS-1:0];
                        r_acc    <= '0;
                        r_mplier <= r_plow;
                        r_cnt    <= CW'(COUNT_BITS);
                        r_state  <= S_MULL;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_MULL: begin
                    if (r_cnt != '0) begin
                        r_acc    <= (r_acc << 1) +
                                    (r_mplier[COUNT_BITS-1] ? PW'(r_range) : '0);
                        r_mplier <= r_mplier << 1;
                        r_cnt    <= r_cnt - 1'b1;
                    end else begin
                        r_rem   <= '0;
                        r_cnt   <= CW'(PW);
                        r_state <= S_DIVL;
                    end
                end
                S_UPD: begin
                    r_high  <= r_low + r_qh - 1'b1;
                    r_low   <= r_low + r_acc[CODE_BITS-1:0];
                    r_steps <= '0;
                    r_any   <= 1'b0;
                    r_state <= S_RENRM;
                end
                S_RENRM: if (out_free) begin
                    if (rn_stop) begin
                        // The held word is the last one of this item.
                        if (r_any) begin
                            r_odata <= '{lead_bit: r_pend.lead_bit,
                                         follow_count: r_pend.follow_count,
                                         last_of_item: 1'b1, end_of_stream: 1'b0};
                        end
                        r_state <= S_IDLE;
                    end else begin
                        if (rn_emit) begin
                            if (r_any) r_odata <= r_pend;
                            r_pend <= '{lead_bit: rn_lead, follow_count: r_uf,
                                        last_of_item: 1'b0, end_of_stream: 1'b0};
                            r_any  <= 1'b1;
                            r_uf   <= '0;
                        end else if (r_uf != UF_MAX) begin
                            r_uf <= r_uf + 1'b1;
                        end
                        r_low   <= rn_low << 1;
                        r_high  <= {rn_high[CODE_BITS-2:0], 1'b1};
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_FLUSH: if (out_free) begin
                    r_odata <= '{lead_bit: !(r_low < CODE_QUARTER),
                                 follow_count: (r_uf != UF_MAX) ? r_uf + 1'b1 : r_uf,
                                 last_of_item: 1'b1, end_of_stream: 1'b1};
                    r_low    <= '0;
                    r_high   <= CODE_MAX;
                    r_uf     <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/aenc_checker.sv */
//------------------------------------------------------------------------------
// aenc_checker
// Port-level checks for the arithmetic encoder, bound to the top level.
//------------------------------------------------------------------------------
module aenc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input aenc_pkg::t_out_word o_data
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result word changed under stall");

    // End of stream is always the last word of its item.
    a_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.end_of_stream |-> o_data.last_of_item)
        else $error("end of stream without last flag");

    // No input is taken while a result word waits.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");

    // A word taken with nothing waiting yields no result on the next cycle.
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid)
        else $error("result word right after accept");

endmodule

bind arithmetic_encoder_static_model aenc_checker u_aenc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);

/* tb/tb_arithmetic_encoder_static_model.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_arithmetic_encoder_static_model
// Self-checking bench for the static-model arithmetic encoder. Words are sent
// from a directed table and then from random table loads, symbol runs and
// flushes. Each result word is compared field by field with the oldest word
// that a bit-accurate encoder model in this bench expects.
//------------------------------------------------------------------------------
module tb_arithmetic_encoder_static_model;

    localparam int NSYM = 64;
    localparam logic [31:0] HALF = 32'h8000_0000;
    localparam logic [31:0] QUARTER = 32'h4000_0000;
    localparam logic [31:0] THREE_QUARTERS = 32'hC000_0000;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    aenc_pkg::t_in_word i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    aenc_pkg::t_out_word o_data;

    // Encoder state as this bench tracks it.
    logic [31:0] enc_low = '0;
    logic [31:0] enc_high = '1;
    logic [31:0] pending_follow = '0;
    logic [29:0] cum_table [NSYM];

    aenc_pkg::t_out_word expected_words[$];
    int fail_count = 0;
    int cycle_count = 0;
    bit long_hold = 1'b0;
    bit hold_done = 1'b0;

    // Directed rows: word plus the result typed in where obvious.
    typedef struct {
        aenc_pkg::t_in_word w;
        bit has_exp;
        aenc_pkg::t_out_word exp_word;
    } t_row;
    t_row rows[$];

    arithmetic_encoder_static_model uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Appends the results that one accepted word causes.
    task automatic predict_words(input aenc_pkg::t_in_word w);
        logic [63:0] total, span, hi_prod, lo_prod;
        aenc_pkg::t_out_word r;
        int n;
        n = 0;
        if (w.command == aenc_pkg::CMD_LOAD) begin
            cum_table[w.table_index] = w.table_value;
        end else if (w.command == aenc_pkg::CMD_ENCODE) begin
            if (w.symbol + 1 < NSYM && cum_table[NSYM-1] != 0) begin
                total = cum_table[NSYM-1];
                span = {31'b0, {1'b0, enc_high} - {1'b0, enc_low} + 33'd1};
                hi_prod = span * cum_table[w.symbol + 1] / total;
                lo_prod = span * cum_table[w.symbol] / total;
                enc_high = enc_low + hi_prod[31:0] - 32'd1;
                enc_low = enc_low + lo_prod[31:0];
                for (int s = 0; s <= 33; s++) begin
                    if (enc_high < HALF || enc_low >= HALF) begin
                        r = '0;
                        r.lead_bit = (enc_low >= HALF) && !(enc_high < HALF);
                        r.follow_count = pending_follow;
                        if (n < 32) begin
                            expected_words = {expected_words, r};
                            n++;
                        end
                        pending_follow = '0;
                    end else if (enc_low >= QUARTER && enc_high < THREE_QUARTERS) begin
                        if (pending_follow != '1) pending_follow++;
                        enc_low -= QUARTER;
                        enc_high -= QUARTER;
                    end else begin
                        break;
                    end
                    enc_high = {enc_high[30:0], 1'b1};
                    enc_low = {enc_low[30:0], 1'b0};
                end
                if (n > 0) expected_words[$].last_of_item = 1'b1;
            end
        end else if (w.command == aenc_pkg::CMD_FLUSH) begin
            if (pending_follow != '1) pending_follow++;
            r.lead_bit = !(enc_low < QUARTER);
            r.follow_count = pending_follow;
            r.last_of_item = 1'b1;
            r.end_of_stream = 1'b1;
            expected_words = {expected_words, r};
            enc_low = '0;
            enc_high = '1;
            pending_follow = '0;
        end
    endtask

    // Sends one word and records what it should produce.
    task automatic send_word(input aenc_pkg::t_in_word w);
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_words(w);
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40)
                                              : $urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    function automatic aenc_pkg::t_in_word make_word(logic [1:0] cmd, int idx,
                                                     logic [29:0] val, int sym);
        aenc_pkg::t_in_word w;
        w.command = cmd;
        w.table_index = idx[5:0];
        w.table_value = val;
        w.symbol = sym[5:0];
        return w;
    endfunction

    // Adds one directed row.
    task automatic add_row(input aenc_pkg::t_in_word w, input bit has_exp,
                           input aenc_pkg::t_out_word e);
        t_row row;
        row.w = w;
        row.has_exp = has_exp;
        row.exp_word = e;
        rows = {rows, row};
    endtask

    // Loads a random non-decreasing cumulative table; sometimes a tiny total.
    task automatic load_random_table(input bit skewed);
        logic [29:0] acc;
        int stepmax;
        acc = '0;
        stepmax = skewed ? 3 : ($urandom_range(0, 1) ? 1000 : 16_000_000);
        for (int i = 0; i < NSYM; i++) begin
            send_word(make_word(aenc_pkg::CMD_LOAD, i, acc, $urandom_range(0, 63)));
            acc += (i == 5 && skewed) ? 30'd5000 : 30'($urandom_range(0, stepmax));
        end
    endtask

    function automatic aenc_pkg::t_in_word random_encode();
        return make_word(aenc_pkg::CMD_ENCODE, $urandom_range(0, 63), 30'($urandom),
                         $urandom_range(0, 62));
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        aenc_pkg::t_out_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word %h", o_data);
                fail_count++;
            end else begin
                e = expected_words.pop_front();
                if (o_data.lead_bit !== e.lead_bit) begin
                    $error("lead_bit exp %0d got %0d", e.lead_bit, o_data.lead_bit);
                    fail_count++;
                end
                if (o_data.follow_count !== e.follow_count) begin
                    $error("follow_count exp %0d got %0d", e.follow_count,
                           o_data.follow_count);
                    fail_count++;
                end
                if (o_data.last_of_item !== e.last_of_item) begin
                    $error("last_of_item exp %0d got %0d", e.last_of_item,
                           o_data.last_of_item);
                    fail_count++;
                end
                if (o_data.end_of_stream !== e.end_of_stream) begin
                    $error("end_of_stream exp %0d got %0d", e.end_of_stream,
                           o_data.end_of_stream);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stalls, with one long hold-off counted here.
    always @(posedge i_clk) begin
        if (long_hold && !hold_done) begin
            i_stall <= 1'b1;
            repeat (600) @(posedge i_clk);
            hold_done <= 1'b1;
            i_stall <= 1'b0;
        end else if (cycle_count % 500 < 150) begin
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 29) == 0) begin
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 2) == 0) begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("arithmetic_encoder_static_model test failed");
            $finish;
        end
    end

    initial begin
        aenc_pkg::t_out_word fe;
        aenc_pkg::t_in_word w;
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: flush right after reset, ignored codes, extremes.
        fe = '0;
        fe.follow_count = 32'd1;
        fe.last_of_item = 1'b1;
        fe.end_of_stream = 1'b1;
        add_row(make_word(aenc_pkg::CMD_FLUSH, 63, '1, 63), 1'b1, fe);
        add_row(make_word(aenc_pkg::CMD_RSVD, 63, '1, 63), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_LOAD, 63, '0, 0), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_ENCODE, 0, '0, 0), 1'b0, fe);   // zero total
        add_row(make_word(aenc_pkg::CMD_ENCODE, 0, '0, 63), 1'b0, fe);  // symbol out of range
        add_row(make_word(aenc_pkg::CMD_LOAD, 0, '0, 0), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_LOAD, 1, 30'd1, 0), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_LOAD, 2, 30'h2000_0000, 0), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_LOAD, 62, 30'h3FFF_FFFE, 0), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_LOAD, 63, '1, 0), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_ENCODE, 0, '0, 0), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_ENCODE, 0, '0, 1), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_ENCODE, 0, '0, 62), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_ENCODE, 0, '0, 1), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_FLUSH, 0, '0, 0), 1'b0, fe);
        // Inconsistent table: decreasing counts wrap the bounds.
        add_row(make_word(aenc_pkg::CMD_LOAD, 1, 30'h3000_0000, 0), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_ENCODE, 0, '0, 1), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_ENCODE, 0, '0, 0), 1'b0, fe);
        add_row(make_word(aenc_pkg::CMD_FLUSH, 0, '0, 0), 1'b0, fe);
        foreach (rows[i]) begin
            if (rows[i].has_exp) begin
                send_word(rows[i].w);
                void'(expected_words.pop_back());
                expected_words = {expected_words, rows[i].exp_word};
            end else begin
                send_word(rows[i].w);
            end
        end

        // Sender waits for every expected word to drain.
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);

        // Random: tables, then symbol runs ending in flushes.
        k = 0;
        while (k < 440) begin
            if (k % 110 == 0) begin
                load_random_table(k == 220);
                k += NSYM;
            end
            if (k == 300) long_hold <= 1'b1;
            case ($urandom_range(0, 19))
                0: w = make_word(aenc_pkg::CMD_FLUSH, $urandom_range(0, 63),
                                 30'($urandom), $urandom_range(0, 63));
                1: w = make_word(aenc_pkg::CMD_RSVD, $urandom_range(0, 63),
                                 30'($urandom), $urandom_range(0, 63));
                2: begin
                    // Rewrite an entry; mostly with its current value, else a random one.
                    w = make_word(aenc_pkg::CMD_LOAD, $urandom_range(1, 62),
                                  30'($urandom), 0);
                    if ($urandom_range(0, 3) != 0)
                        w.table_value = cum_table[w.table_index];
                end
                3: w = make_word(aenc_pkg::CMD_ENCODE, 0, 30'($urandom), 63);
                default: w = random_encode();
            endcase
            send_word(w);
            k++;
        end
        i_valid <= 1'b0;
        while (expected_words.size() != 0 || (long_hold && !hold_done)) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("arithmetic_encoder_static_model test passed");
        end else begin
            $display("arithmetic_encoder_static_model test failed");
        end
        $finish;
    end
endmodule
